// ----- src/qrr_pkg.sv -----
`timescale 1ns / 1ps
// qrr_pkg: widths, codes and stage tag types for the quadratic real roots core
// no dependencies

package qrr_pkg;

  localparam int COEF_WIDTH = 16;
  localparam int AW         = COEF_WIDTH + 1;
  localparam int DW         = 2 * AW;
  localparam int MW         = DW - 1 + 14;
  localparam int RW         = (MW + 1) / 2;
  localparam int PW         = COEF_WIDTH + 7;
  localparam int FW         = ((PW - 1 > RW) ? PW - 1 : RW) + 2;
  localparam int DVW        = COEF_WIDTH + 1;
  localparam int ROOT_WIDTH = 24;
  localparam int ROOT_SCALE = 100;
  localparam int SCALE_SQ   = ROOT_SCALE * ROOT_SCALE;
  localparam int ROOT_LIMIT = 6000000;

  typedef enum logic [1:0] {
    ST_NO_ROOT = 2'd0,
    ST_DOUBLE  = 2'd1,
    ST_TWO     = 2'd2,
    ST_A_ZERO  = 2'd3
  } root_status_t;

  typedef struct packed {
    root_status_t                   status;
    logic        [COEF_WIDTH-1:0]   a;
    logic signed [PW-1:0]           p;
  } sq_tag_t;

  typedef struct packed {
    root_status_t status;
    logic         neg;
  } dv_tag_t;

endpackage

// ----- src/qrr_if.sv -----
`timescale 1ns / 1ps
// qrr_coef_if and qrr_root_if: valid/ready request channels for coefficients and roots
// depends on qrr_pkg

interface qrr_coef_if import qrr_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coef_a;
  logic signed [COEF_WIDTH-1:0] coef_b;
  logic signed [COEF_WIDTH-1:0] coef_c;

  modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

interface qrr_root_if import qrr_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic        [1:0]            root_status;
  logic signed [ROOT_WIDTH-1:0] root_low;
  logic signed [ROOT_WIDTH-1:0] root_high;

  modport source (output valid, output root_status, output root_low, output root_high,
                  input ready);
  modport sink   (input valid, input root_status, input root_low, input root_high,
                  output ready);
endinterface

// ----- src/qrr_front.sv -----
`timescale 1ns / 1ps
// qrr_front: sign normalisation, products, discriminant and scaling, four stages
// depends on qrr_pkg, qrr_if

module qrr_front import qrr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  qrr_coef_if.sink        coef_in,
  output logic            out_valid,
  output logic [MW-1:0]   out_m,
  output sq_tag_t         out_tag
);

  logic signed [AW-1:0] a_x, b_x, c_x;
  logic                 flip;

  logic                 v1, v2, v3, v4;
  logic signed [AW-1:0] a1, b1, c1;
  logic                 az1, az2, az3, az4;
  logic signed [DW-1:0] bb2, ac2, disc3;
  logic [COEF_WIDTH-1:0] a2, a3, a4;
  logic signed [PW-1:0] p2, p3, p4;
  logic [MW-1:0]        m4;
  root_status_t         st3, st4;

  assign coef_in.ready = en;

  assign a_x  = {coef_in.coef_a[COEF_WIDTH-1], coef_in.coef_a};
  assign b_x  = {coef_in.coef_b[COEF_WIDTH-1], coef_in.coef_b};
  assign c_x  = {coef_in.coef_c[COEF_WIDTH-1], coef_in.coef_c};
  assign flip = coef_in.coef_a[COEF_WIDTH-1];

  always_comb begin
    priority if (az3) begin
      st3 = ST_A_ZERO;
    end else if (disc3 < 0) begin
      st3 = ST_NO_ROOT;
    end else if (disc3 == '0) begin
      st3 = ST_DOUBLE;
    end else begin
      st3 = ST_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= coef_in.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    if (en) begin
      a1    <= flip ? -a_x : a_x;
      b1    <= flip ? -b_x : b_x;
      c1    <= flip ? -c_x : c_x;
      az1   <= (coef_in.coef_a == '0);
      bb2   <= b1 * b1;
      ac2   <= a1 * c1;
      p2    <= -(PW'(b1) * PW'(ROOT_SCALE));
      a2    <= a1[COEF_WIDTH-1:0];
      az2   <= az1;
      disc3 <= bb2 - (ac2 <<< 2);
      p3    <= p2;
      a3    <= a2;
      az3   <= az2;
      m4    <= MW'(disc3[DW-2:0]) * MW'(SCALE_SQ);
      st4   <= st3;
      p4    <= p3;
      a4    <= a3;
      az4   <= az3;
    end
  end

  assign out_valid      = v4;
  assign out_m          = m4;
  assign out_tag.status = st4;
  assign out_tag.a      = a4;
  assign out_tag.p      = p4;

endmodule

// ----- src/qrr_sqrt.sv -----
`timescale 1ns / 1ps
// qrr_sqrt: pipelined integer square root, one root bit per stage, with exactness flag
// depends on qrr_pkg

module qrr_sqrt import qrr_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [MW-1:0] in_m,
  input  sq_tag_t       in_tag,
  output logic          out_valid,
  output logic [RW-1:0] out_root,
  output logic          out_exact,
  output sq_tag_t       out_tag
);

  logic [RW+1:0]   rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [2*RW-1:0] mv_q   [RW];
  sq_tag_t         tag_q  [RW];
  logic            val_q  [RW];

  for (genvar gi = 0; gi < RW; gi++) begin : g_st
    logic [RW+1:0]   rem_i;
    logic [RW-1:0]   root_i;
    logic [2*RW-1:0] mv_i;
    sq_tag_t         tag_i;
    logic            val_i;
    logic [RW+3:0]   cur, trial;
    logic            ge;

    if (gi == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign mv_i   = (2*RW)'(in_m);
      assign tag_i  = in_tag;
      assign val_i  = in_valid;
    end else begin : g_next
      assign rem_i  = rem_q[gi-1];
      assign root_i = root_q[gi-1];
      assign mv_i   = mv_q[gi-1];
      assign tag_i  = tag_q[gi-1];
      assign val_i  = val_q[gi-1];
    end

    assign cur   = {rem_i, mv_i[2*RW-1 -: 2]};
    assign trial = (RW+4)'({root_i, 2'b01});
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        val_q[gi] <= 1'b0;
      end else if (en) begin
        val_q[gi] <= val_i;
      end
      if (en) begin
        rem_q[gi]  <= ge ? (RW+2)'(cur - trial) : (RW+2)'(cur);
        root_q[gi] <= {root_i[RW-2:0], ge};
        mv_q[gi]   <= mv_i << 2;
        tag_q[gi]  <= tag_i;
      end
    end
  end

  assign out_valid = val_q[RW-1];
  assign out_root  = root_q[RW-1];
  assign out_exact = (rem_q[RW-1] == '0);
  assign out_tag   = tag_q[RW-1];

endmodule

// ----- src/qrr_div.sv -----
`timescale 1ns / 1ps
// qrr_div: pipelined restoring unsigned divider, one quotient bit per stage
// depends on qrr_pkg

module qrr_div import qrr_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  logic [FW-1:0]  in_num,
  input  logic [DVW-1:0] in_den,
  input  dv_tag_t        in_tag,
  output logic           out_valid,
  output logic [FW-1:0]  out_quo,
  output dv_tag_t        out_tag
);

  logic [DVW-1:0] rem_q [FW];
  logic [FW-1:0]  quo_q [FW];
  logic [FW-1:0]  num_q [FW];
  logic [DVW-1:0] den_q [FW];
  dv_tag_t        tag_q [FW];
  logic           val_q [FW];

  for (genvar gi = 0; gi < FW; gi++) begin : g_st
    logic [DVW-1:0] rem_i, den_i;
    logic [FW-1:0]  quo_i, num_i;
    dv_tag_t        tag_i;
    logic           val_i;
    logic [DVW:0]   cur;
    logic           ge;

    if (gi == 0) begin : g_first
      assign rem_i = '0;
      assign quo_i = '0;
      assign num_i = in_num;
      assign den_i = in_den;
      assign tag_i = in_tag;
      assign val_i = in_valid;
    end else begin : g_next
      assign rem_i = rem_q[gi-1];
      assign quo_i = quo_q[gi-1];
      assign num_i = num_q[gi-1];
      assign den_i = den_q[gi-1];
      assign tag_i = tag_q[gi-1];
      assign val_i = val_q[gi-1];
    end

    assign cur = {rem_i, num_i[FW-1]};
    assign ge  = (cur >= (DVW+1)'(den_i));

    always_ff @(posedge clk) begin
      if (rst) begin
        val_q[gi] <= 1'b0;
      end else if (en) begin
        val_q[gi] <= val_i;
      end
      if (en) begin
        rem_q[gi] <= ge ? DVW'(cur - (DVW+1)'(den_i)) : DVW'(cur);
        quo_q[gi] <= {quo_i[FW-2:0], ge};
        num_q[gi] <= num_i << 1;
        den_q[gi] <= den_i;
        tag_q[gi] <= tag_i;
      end
    end
  end

  assign out_valid = val_q[FW-1];
  assign out_quo   = quo_q[FW-1];
  assign out_tag   = tag_q[FW-1];

endmodule

// ----- src/quadratic_real_roots_core.sv -----
`timescale 1ns / 1ps
// throughput: one request per cycle; ready is registered and drops only while the
// output skid register holds a second result
// reset: synchronous, clears all stage valid bits and the output and skid valid flags
// quadratic_real_roots_core: front end, square root and two divider pipelines, output skid
// depends on qrr_pkg, qrr_if, qrr_front, qrr_sqrt, qrr_div

module quadratic_real_roots_core import qrr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  qrr_coef_if.sink   coef_in,
  qrr_root_if.source root_out
);

  localparam int CMPW = (FW > ROOT_WIDTH) ? FW : ROOT_WIDTH;

  logic          en;
  logic          fr_valid;
  logic [MW-1:0] fr_m;
  sq_tag_t       fr_tag;

  logic          sq_valid;
  logic [RW-1:0] sq_root;
  logic          sq_exact;
  sq_tag_t       sq_tag;

  logic signed [FW-1:0] p_s, r_s, a_s, ex_s;
  logic signed [FW-1:0] fl_lo, ce_lo, fl_hi, ce_hi;

  logic           pr_valid;
  logic [FW-1:0]  pr_num_lo, pr_num_hi;
  logic [DVW-1:0] pr_den;
  dv_tag_t        pr_tag_lo, pr_tag_hi;

  logic          dl_valid, dh_valid;
  logic [FW-1:0] dl_quo, dh_quo;
  dv_tag_t       dl_tag, dh_tag;

  logic                         fin_valid;
  logic [1:0]                   fin_status;
  logic signed [ROOT_WIDTH-1:0] fin_lo, fin_hi;

  logic                         out_valid, skid_valid;
  logic [1:0]                   out_status, skid_status;
  logic signed [ROOT_WIDTH-1:0] out_lo, out_hi, skid_lo, skid_hi;

  function automatic logic signed [ROOT_WIDTH-1:0] finish_root(
    input logic [FW-1:0] quo,
    input logic          neg
  );
    logic [CMPW-1:0]       q_w;
    logic [ROOT_WIDTH-1:0] mag;
    q_w = CMPW'(quo);
    mag = (q_w > CMPW'(ROOT_LIMIT)) ? ROOT_WIDTH'(ROOT_LIMIT) : q_w[ROOT_WIDTH-1:0];
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  assign en = ~skid_valid;

  qrr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .coef_in   (coef_in),
    .out_valid (fr_valid),
    .out_m     (fr_m),
    .out_tag   (fr_tag)
  );

  qrr_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .in_m      (fr_m),
    .in_tag    (fr_tag),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_exact (sq_exact),
    .out_tag   (sq_tag)
  );

  // rounding bounds around p -/+ sqrt
  assign p_s   = FW'(sq_tag.p);
  assign r_s   = FW'({1'b0, sq_root});
  assign a_s   = FW'({1'b0, sq_tag.a});
  assign ex_s  = {{(FW-1){1'b0}}, ~sq_exact};
  assign fl_hi = p_s + r_s;
  assign ce_hi = p_s + r_s + ex_s;
  assign fl_lo = p_s - r_s - ex_s;
  assign ce_lo = p_s - r_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_valid <= 1'b0;
    end else if (en) begin
      pr_valid <= sq_valid;
    end
    if (en) begin
      pr_num_lo        <= (fl_lo >= 0) ? FW'(fl_lo + a_s) : FW'(a_s - ce_lo);
      pr_num_hi        <= (fl_hi >= 0) ? FW'(fl_hi + a_s) : FW'(a_s - ce_hi);
      pr_den           <= {sq_tag.a, 1'b0};
      pr_tag_lo.status <= sq_tag.status;
      pr_tag_lo.neg    <= (fl_lo < 0);
      pr_tag_hi.status <= sq_tag.status;
      pr_tag_hi.neg    <= (fl_hi < 0);
    end
  end

  qrr_div u_div_lo (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pr_valid),
    .in_num    (pr_num_lo),
    .in_den    (pr_den),
    .in_tag    (pr_tag_lo),
    .out_valid (dl_valid),
    .out_quo   (dl_quo),
    .out_tag   (dl_tag)
  );

  qrr_div u_div_hi (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pr_valid),
    .in_num    (pr_num_hi),
    .in_den    (pr_den),
    .in_tag    (pr_tag_hi),
    .out_valid (dh_valid),
    .out_quo   (dh_quo),
    .out_tag   (dh_tag)
  );

  always_comb begin
    fin_valid  = dl_valid & dh_valid;
    fin_status = dl_tag.status;
    if (dl_tag.status == ST_DOUBLE || dl_tag.status == ST_TWO) begin
      fin_lo = finish_root(dl_quo, dl_tag.neg);
      fin_hi = finish_root(dh_quo, dh_tag.neg);
    end else begin
      fin_lo = '0;
      fin_hi = '0;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (root_out.ready) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (fin_valid) begin
      if (!out_valid || root_out.ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (root_out.ready) begin
      out_valid <= 1'b0;
    end

    if (skid_valid) begin
      if (root_out.ready) begin
        out_status <= skid_status;
        out_lo     <= skid_lo;
        out_hi     <= skid_hi;
      end
    end else if (fin_valid) begin
      if (!out_valid || root_out.ready) begin
        out_status <= fin_status;
        out_lo     <= fin_lo;
        out_hi     <= fin_hi;
      end else begin
        skid_status <= fin_status;
        skid_lo     <= fin_lo;
        skid_hi     <= fin_hi;
      end
    end
  end

  assign root_out.valid       = out_valid;
  assign root_out.root_status = out_status;
  assign root_out.root_low    = out_lo;
  assign root_out.root_high   = out_hi;

endmodule

// ----- test/qrr_checker.sv -----
`timescale 1ns / 1ps
// qrr_checker: watches the coefficient and root channels, predicts each root pair
// depends on qrr_pkg and qrr_if; reports a mismatch count to the testbench top

module qrr_checker import qrr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  qrr_coef_if.sink   coef_mon,
  qrr_root_if.sink   root_mon,
  output int         errors,
  output int         pending,
  output int         accepted,
  output int         returned
);

  typedef struct {
    root_status_t                 status;
    logic signed [ROOT_WIDTH-1:0] lo;
    logic signed [ROOT_WIDTH-1:0] hi;
  } roots_t;

  roots_t expected_roots[$];

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint round_root(longint p, bit upper, longint r, bit exact,
                                        longint a);
    longint fl, ce, res;
    if (upper) begin
      fl = p + r;
      ce = p + r + (exact ? 0 : 1);
    end else begin
      fl = p - r - (exact ? 0 : 1);
      ce = p - r;
    end
    if (fl >= 0) res = floor_quot(fl + a, 2 * a);
    else res = -floor_quot(a - ce, 2 * a);
    if (res > ROOT_LIMIT) res = ROOT_LIMIT;
    if (res < -ROOT_LIMIT) res = -ROOT_LIMIT;
    return res;
  endfunction

  function automatic roots_t solve_quadratic(logic signed [COEF_WIDTH-1:0] ca,
                                             logic signed [COEF_WIDTH-1:0] cb,
                                             logic signed [COEF_WIDTH-1:0] cc);
    roots_t o;
    longint a, b, c, disc, p, r;
    longint unsigned m;
    a = ca;
    b = cb;
    c = cc;
    o.status = ST_A_ZERO;
    o.lo = '0;
    o.hi = '0;
    if (a != 0) begin
      if (a < 0) begin
        a = -a;
        b = -b;
        c = -c;
      end
      disc = b * b - 4 * a * c;
      if (disc < 0) begin
        o.status = ST_NO_ROOT;
      end else begin
        m = longint'(disc) * SCALE_SQ;
        r = int_sqrt(m);
        p = -ROOT_SCALE * b;
        o.lo = ROOT_WIDTH'(round_root(p, 1'b0, r, (r * r) == m, a));
        o.hi = ROOT_WIDTH'(round_root(p, 1'b1, r, (r * r) == m, a));
        o.status = (disc == 0) ? ST_DOUBLE : ST_TWO;
      end
    end
    return o;
  endfunction

  always @(posedge clk) begin
    roots_t e;
    int     bad;
    bad = 0;
    if (rst) begin
      errors <= 0;
      accepted <= 0;
      returned <= 0;
      expected_roots.delete();
    end else begin
      if (coef_mon.valid && coef_mon.ready) begin
        expected_roots.push_back(solve_quadratic(coef_mon.coef_a, coef_mon.coef_b,
                                                 coef_mon.coef_c));
        accepted <= accepted + 1;
      end
      if (root_mon.valid && root_mon.ready) begin
        returned <= returned + 1;
        if (expected_roots.size() == 0) begin
          $error("unexpected result");
          bad = bad + 1;
        end else begin
          e = expected_roots.pop_front();
          if (root_mon.root_status !== e.status) begin
            $error("root_status expected %0d actual %0d", e.status, root_mon.root_status);
            bad = bad + 1;
          end
          if (root_mon.root_low !== e.lo) begin
            $error("root_low expected %0d actual %0d", e.lo, root_mon.root_low);
            bad = bad + 1;
          end
          if (root_mon.root_high !== e.hi) begin
            $error("root_high expected %0d actual %0d", e.hi, root_mon.root_high);
            bad = bad + 1;
          end
        end
      end
      if (bad != 0) errors <= errors + bad;
    end
  end

  assign pending = expected_roots.size();

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// tb: drives coefficient requests into quadratic_real_roots_core with random gaps and stalls
// depends on qrr_pkg, qrr_if, qrr_checker and the core

module tb;
  import qrr_pkg::*;

  localparam int LATENCY = 4 + RW + 1 + FW + 1;
  localparam int WATCHDOG = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors, pending, accepted, returned;
  int   idle_cycles;

  qrr_coef_if coef_ch ();
  qrr_root_if root_ch ();

  quadratic_real_roots_core dut (.clk(clk), .rst(rst), .coef_in(coef_ch.sink),
                                 .root_out(root_ch.source));

  qrr_checker chk (.clk(clk), .rst(rst), .coef_mon(coef_ch.sink), .root_mon(root_ch.sink),
                   .errors(errors), .pending(pending), .accepted(accepted),
                   .returned(returned));

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (coef_ch.valid && coef_ch.ready) || (root_ch.valid && root_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: %0d items sent, %0d results seen", accepted, returned);
      $display("tb: FAIL");
      $finish;
    end
  end

  // result side stalls
  initial begin
    int k, n;
    root_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      root_ch.ready <= (n == 0);
      for (k = 0; k < n; k++) @(negedge clk);
      root_ch.ready <= 1'b1;
      @(negedge clk);
      while (!(root_ch.valid && root_ch.ready)) @(negedge clk);
    end
  end

  task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c, bit gaps);
    int n;
    n = gaps ? $urandom_range(0, 4) : 0;
    if (n > 0) begin
      coef_ch.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    coef_ch.valid <= 1'b1;
    coef_ch.coef_a <= a;
    coef_ch.coef_b <= b;
    coef_ch.coef_c <= c;
    while (!coef_ch.ready) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic send_from_roots(bit gaps);
    int r1, r2, k;
    r1 = $signed($urandom_range(0, 200)) - 100;
    r2 = ($urandom_range(0, 3) == 0) ? r1 : $signed($urandom_range(0, 200)) - 100;
    k = $urandom_range(1, 3) * (($urandom_range(0, 1) == 1) ? -1 : 1);
    send_coefs(16'(k), 16'(-k * (r1 + r2)), 16'(k * r1 * r2), gaps);
  endtask

  initial begin
    int i;
    bit gaps;
    coef_ch.valid = 1'b0;
    coef_ch.coef_a = '0;
    coef_ch.coef_b = '0;
    coef_ch.coef_c = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed corners
    send_coefs(16'h0000, 16'h1234, 16'h0005, 1'b0);
    send_coefs(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_coefs(16'h0001, 16'h0000, 16'h0001, 1'b0);
    send_coefs(16'h0001, 16'hfffe, 16'h0001, 1'b0);
    send_coefs(16'h0001, 16'hfffd, 16'h0002, 1'b0);
    send_coefs(16'hffff, 16'h0003, 16'hfffe, 1'b0);
    send_coefs(16'h0001, 16'h8000, 16'h8000, 1'b0);
    send_coefs(16'h7fff, 16'h7fff, 16'h8000, 1'b0);
    send_coefs(16'h8000, 16'h7fff, 16'h7fff, 1'b0);
    send_coefs(16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_coefs(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
    send_coefs(16'h0001, 16'h7fff, 16'h0000, 1'b0);
    send_coefs(16'h0001, 16'h8000, 16'h0000, 1'b0);
    send_coefs(16'h0008, 16'h0000, 16'hfffe, 1'b0);
    send_coefs(16'h0002, 16'h0001, 16'h0000, 1'b0);
    send_coefs(16'h0002, 16'hffff, 16'h0000, 1'b0);
    send_coefs(16'h0003, 16'h0001, 16'h0000, 1'b0);
    send_coefs(16'h0001, 16'h0000, 16'hffff, 1'b0);
    send_coefs(16'hffff, 16'h0000, 16'h0001, 1'b0);
    send_coefs(16'hffff, 16'hffff, 16'hffff, 1'b0);
    send_coefs(16'h5555, 16'haaaa, 16'h5555, 1'b0);
    // pause until every outstanding result has come back
    coef_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    for (i = 0; i < 1200; i++) begin
      gaps = ((i / 100) % 3) != 1;
      case ($urandom_range(0, 5))
        0, 1: send_from_roots(gaps);
        2:    send_coefs(16'($urandom), 16'($urandom), 16'($urandom), gaps);
        3:    send_coefs(16'($urandom_range(0, 15)) - 16'd8, 16'($urandom_range(0, 63)) - 16'd32,
                         16'($urandom_range(0, 63)) - 16'd32, gaps);
        4:    send_coefs(16'($urandom_range(0, 3)) - 16'd1, 16'($urandom), 16'($urandom), gaps);
        default: send_coefs(16'($urandom), 16'($urandom_range(0, 31)) - 16'd16,
                            16'($urandom), gaps);
      endcase
      if (i == 600) begin
        coef_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
    end
    coef_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    $display("covered %0d coefficient sets: corners, zero leading term, no/double/two roots",
             accepted);
    $display("with random gaps on both channels; %0d results checked", returned);
    if (errors == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
